>>> rtl/core/dsa_pkg.sv
// ----------------------------------------------------------------------------
// Descriptor slot allocator package
// Shared widths, codes, reset values and the job record passed from the
// control unit to the result stage.
// ----------------------------------------------------------------------------
package dsa_pkg;

   // Field widths fixed by the interface.
   localparam int IDX_W    = 10;
   localparam int ADDR_W   = 64;
   localparam int STRIDE_W = 9;
   localparam int CNT_W    = 11;
   localparam int STATUS_W = 2;

   // Default built depth of the free stack.
   localparam int DEFAULT_MAX_SLOTS = 1024;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_BASE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY  = 2'd2;

   // Configuration reset values.
   localparam logic [ADDR_W-1:0]   HEAP_BASE_RST = '0;
   localparam logic [STRIDE_W-1:0] STRIDE_RST    = 9'd32;
   localparam logic [CNT_W-1:0]    CAPACITY_RST  = 11'd1024;

   // Request kinds.
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK               = 2'd0,
      STATUS_OUT_OF_SLOTS     = 2'd1,
      STATUS_FREE_NONE_ACTIVE = 2'd2
   } status_type;

   // One finished request, waiting for its address to be formed.
   typedef struct packed {
      logic [IDX_W-1:0] slot;
      logic             addr_en;
      status_type       status;
      logic [CNT_W-1:0] active;
   } job_type;

endpackage

>>> rtl/core/dsa_free_stack.sv
// ----------------------------------------------------------------------------
// Free stack memory
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module dsa_free_stack #(
   parameter int DEPTH = dsa_pkg::DEFAULT_MAX_SLOTS,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [dsa_pkg::IDX_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output logic [dsa_pkg::IDX_W-1:0] rd_data_ff
);

   logic [dsa_pkg::IDX_W-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port with registered data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

>>> rtl/core/dsa_ctrl.sv
// ----------------------------------------------------------------------------
// Allocator control
// Holds the bump pointer, stack top and active count, drives the free stack
// memory and hands each finished request to the result stage as a job.
// ----------------------------------------------------------------------------
module dsa_ctrl #(
   parameter int MAX_SLOTS = dsa_pkg::DEFAULT_MAX_SLOTS
) (
   input  logic                      clock,
   input  logic                      reset,
   // Request side.
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_kind,
   input  logic [dsa_pkg::IDX_W-1:0] req_index,
   // Configuration.
   input  logic [dsa_pkg::CNT_W-1:0] capacity,
   // Job to the result stage.
   output logic                      job_valid,
   output dsa_pkg::job_type          job,
   input  logic                      job_taken
);

   localparam int AW    = $clog2(MAX_SLOTS);
   localparam int CW    = $clog2(MAX_SLOTS + 1);
   localparam int CMP_W = (CW > dsa_pkg::CNT_W) ? CW : dsa_pkg::CNT_W;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_READ   = 3'b010,
      ST_RESULT = 3'b100
   } state_type;

   state_type                 state_ff, state_in;
   logic [CW-1:0]             fresh_ff, fresh_in;
   logic [CW-1:0]             top_ff, top_in;
   logic [CW-1:0]             active_ff, active_in;
   logic [dsa_pkg::IDX_W-1:0] slot_ff, slot_in;
   logic                      addr_en_ff, addr_en_in;
   dsa_pkg::status_type       status_ff, status_in;

   logic [CMP_W-1:0]          cap_ext, max_ext, eff_cap, fresh_ext, active_ext;
   logic [CW-1:0]             top_dec;
   logic                      mem_wr_en, mem_rd_en;
   logic [dsa_pkg::IDX_W-1:0] mem_rd_data;

   // Effective capacity saturates at the built depth.
   always_comb begin
      cap_ext    = CMP_W'(capacity);
      max_ext    = CMP_W'(MAX_SLOTS);
      eff_cap    = (cap_ext > max_ext) ? max_ext : cap_ext;
      fresh_ext  = CMP_W'(fresh_ff);
      active_ext = CMP_W'(active_ff);
      top_dec    = top_ff - CW'(1);
   end

   dsa_free_stack #(
      .DEPTH (MAX_SLOTS),
      .AW    (AW)
   ) u_stack (
      .clock      (clock),
      .wr_en      (mem_wr_en),
      .wr_addr    (top_ff[AW-1:0]),
      .wr_data    (req_index),
      .rd_en      (mem_rd_en),
      .rd_addr    (top_dec[AW-1:0]),
      .rd_data_ff (mem_rd_data)
   );

   // Request decode, counter updates and sequencing.
   always_comb begin
      state_in   = state_ff;
      fresh_in   = fresh_ff;
      top_in     = top_ff;
      active_in  = active_ff;
      slot_in    = slot_ff;
      addr_en_in = addr_en_ff;
      status_in  = status_ff;
      mem_wr_en  = 1'b0;
      mem_rd_en  = 1'b0;
      req_ready  = 1'b0;
      job_valid  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in   = ST_RESULT;
               slot_in    = '0;
               addr_en_in = 1'b0;
               status_in  = dsa_pkg::STATUS_OK;
               if (req_kind == dsa_pkg::KIND_ALLOC) begin
                  if (fresh_ext < eff_cap) begin
                     // Bump a never-used slot.
                     slot_in    = fresh_ext[dsa_pkg::IDX_W-1:0];
                     fresh_in   = fresh_ff + CW'(1);
                     active_in  = active_ff + CW'(1);
                     addr_en_in = 1'b1;
                  end else if (top_ff != '0) begin
                     // Pop the most recently freed slot; data arrives next cycle.
                     mem_rd_en  = 1'b1;
                     top_in     = top_dec;
                     active_in  = active_ff + CW'(1);
                     addr_en_in = 1'b1;
                     state_in   = ST_READ;
                  end else begin
                     status_in = dsa_pkg::STATUS_OUT_OF_SLOTS;
                  end
               end else begin
                  if (active_ff == '0) begin
                     status_in = dsa_pkg::STATUS_FREE_NONE_ACTIVE;
                  end else begin
                     // Push the returned slot unless the stack is full.
                     if (CMP_W'(top_ff) < max_ext) begin
                        mem_wr_en = 1'b1;
                        top_in    = top_ff + CW'(1);
                     end
                     active_in = active_ff - CW'(1);
                  end
               end
            end
         end
         ST_READ: begin
            slot_in  = mem_rd_data;
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            job_valid = 1'b1;
            if (job_taken) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign job.slot    = slot_ff;
   assign job.addr_en = addr_en_ff;
   assign job.status  = status_ff;
   assign job.active  = active_ext[dsa_pkg::CNT_W-1:0];

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fresh_ff  <= '0;
         top_ff    <= '0;
         active_ff <= '0;
      end else begin
         state_ff  <= state_in;
         fresh_ff  <= fresh_in;
         top_ff    <= top_in;
         active_ff <= active_in;
      end
   end

   // Job payload.
   always_ff @(posedge clock) begin
      slot_ff    <= slot_in;
      addr_en_ff <= addr_en_in;
      status_ff  <= status_in;
   end

endmodule

>>> rtl/core/dsa_result.sv
// ----------------------------------------------------------------------------
// Result stage
// Forms the slot address and holds the response in an output register.
// ----------------------------------------------------------------------------
module dsa_result (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         job_valid,
   input  dsa_pkg::job_type             job,
   output logic                         job_taken,
   input  logic [dsa_pkg::ADDR_W-1:0]   heap_base,
   input  logic [dsa_pkg::STRIDE_W-1:0] stride,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [dsa_pkg::IDX_W-1:0]    rsp_slot,
   output logic [dsa_pkg::ADDR_W-1:0]   rsp_addr,
   output logic [dsa_pkg::STATUS_W-1:0] rsp_status,
   output logic [dsa_pkg::CNT_W-1:0]    rsp_active
);

   localparam int PROD_W = dsa_pkg::IDX_W + dsa_pkg::STRIDE_W;

   logic                         valid_ff, valid_in;
   logic [dsa_pkg::IDX_W-1:0]    slot_ff;
   logic [dsa_pkg::ADDR_W-1:0]   addr_ff, addr_in;
   logic [dsa_pkg::STATUS_W-1:0] status_ff;
   logic [dsa_pkg::CNT_W-1:0]    active_ff;
   logic [PROD_W-1:0]            offset;

   // The output register loads when empty or being drained.
   assign job_taken = job_valid && (!valid_ff || rsp_ready);

   // Address is only meaningful for a successful allocation.
   always_comb begin
      offset  = PROD_W'(job.slot) * PROD_W'(stride);
      addr_in = job.addr_en ? (heap_base + dsa_pkg::ADDR_W'(offset)) : '0;
      if (job_taken) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_taken) begin
         slot_ff   <= job.slot;
         addr_ff   <= addr_in;
         status_ff <= job.status;
         active_ff <= job.active;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_slot   = slot_ff;
   assign rsp_addr   = addr_ff;
   assign rsp_status = status_ff;
   assign rsp_active = active_ff;

endmodule

>>> rtl/core/descriptor_slot_allocator.sv
// ----------------------------------------------------------------------------
// Descriptor slot allocator
// Bump allocator over a fixed descriptor heap, reusing freed slots in
// last-in first-out order from a stack memory.
//
// Channel   Direction  Handshake              Contents
// req       in         req_tvalid/req_tready  tdata: free_index; tuser: kind
// rsp       out        rsp_tvalid/rsp_tready  tdata: slot_index, slot_address,
//                                             active_count; tuser: status
// csr       in         csr_we (no stall)      heap_base, stride, capacity
//
// The control unit takes no new request until its last job is handed on, and
// a pop of the free stack adds the read state, since the stack read is registered.
// The response is loaded from the result state, which a pop reaches via the read state.
// Reset is synchronous; counters clear and the stack needs no clearing.
// A full output register holds the next job in the control unit, which then
// stops taking requests until the response is taken.
// ----------------------------------------------------------------------------
module descriptor_slot_allocator #(
   parameter int MAX_SLOTS = dsa_pkg::DEFAULT_MAX_SLOTS
) (
   input  logic                          clock,
   input  logic                          reset,
   // Request channel.
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [15:0]                   req_tdata,  // [9:0] free_index
   input  logic [0:0]                    req_tuser,  // [0] kind
   // Response channel.
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [9:0] slot_index, [73:10] slot_address, [84:74] active_count
   output logic [87:0]                   rsp_tdata,
   output logic [1:0]                    rsp_tuser,  // [1:0] status
   // Configuration port.
   input  logic                          csr_we,
   input  logic [dsa_pkg::CSR_IDX_W-1:0] csr_addr,
   input  logic [dsa_pkg::ADDR_W-1:0]    csr_wdata
);

   logic [dsa_pkg::ADDR_W-1:0]   heap_base_ff;
   logic [dsa_pkg::STRIDE_W-1:0] stride_ff;
   logic [dsa_pkg::CNT_W-1:0]    capacity_ff;

   logic                         job_valid, job_taken;
   dsa_pkg::job_type             job;
   logic [dsa_pkg::IDX_W-1:0]    rsp_slot;
   logic [dsa_pkg::ADDR_W-1:0]   rsp_addr;
   logic [dsa_pkg::CNT_W-1:0]    rsp_active;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff <= dsa_pkg::HEAP_BASE_RST;
         stride_ff    <= dsa_pkg::STRIDE_RST;
         capacity_ff  <= dsa_pkg::CAPACITY_RST;
      end else if (csr_we) begin
         if (csr_addr == dsa_pkg::CSR_HEAP_BASE) begin
            heap_base_ff <= csr_wdata;
         end
         if (csr_addr == dsa_pkg::CSR_STRIDE) begin
            stride_ff <= csr_wdata[dsa_pkg::STRIDE_W-1:0];
         end
         if (csr_addr == dsa_pkg::CSR_CAPACITY) begin
            capacity_ff <= csr_wdata[dsa_pkg::CNT_W-1:0];
         end
      end
   end

   dsa_ctrl #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_kind  (req_tuser[0]),
      .req_index (req_tdata[dsa_pkg::IDX_W-1:0]),
      .capacity  (capacity_ff),
      .job_valid (job_valid),
      .job       (job),
      .job_taken (job_taken)
   );

   dsa_result u_result (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (job_valid),
      .job        (job),
      .job_taken  (job_taken),
      .heap_base  (heap_base_ff),
      .stride     (stride_ff),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_slot   (rsp_slot),
      .rsp_addr   (rsp_addr),
      .rsp_status (rsp_tuser),
      .rsp_active (rsp_active)
   );

   // Pack the response fields, slot index in the lowest bits.
   assign rsp_tdata = {3'b000, rsp_active, rsp_addr, rsp_slot};

endmodule

>>> rtl/core/dsa_checker.sv
// ----------------------------------------------------------------------------
// Descriptor slot allocator checker
// Port-level assertions on the response stream, bound to the top level.
// ----------------------------------------------------------------------------
module dsa_checker #(
   parameter int MAX_SLOTS = dsa_pkg::DEFAULT_MAX_SLOTS
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [87:0]                   rsp_tdata,
   input logic [1:0]                    rsp_tuser
);

   // A stalled response keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser))
   else $error("stalled response changed");

   // Error responses carry neither a slot index nor an address.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != dsa_pkg::STATUS_OK) |-> rsp_tdata[73:0] == '0)
   else $error("error response carries a slot");

   // A rejected free can only happen with no active slots.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == dsa_pkg::STATUS_FREE_NONE_ACTIVE)
         |-> rsp_tdata[84:74] == '0)
   else $error("free rejected while slots are active");

   // The active count never exceeds the built depth.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> 32'(rsp_tdata[84:74]) <= 32'(MAX_SLOTS))
   else $error("active count above built depth");

endmodule

bind descriptor_slot_allocator dsa_checker #(.MAX_SLOTS(MAX_SLOTS)) u_dsa_checker (.*);

>>> tb/slot_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// Descriptor slot allocator scoreboard
// Tracks the allocator's counters, free stack and registers, predicts the
// response to every accepted request and checks the responses in order.
// ----------------------------------------------------------------------------
package slot_scoreboard_pkg;

   // Built depth of the allocator under test.
   localparam int SLOT_DEPTH = dsa_pkg::DEFAULT_MAX_SLOTS;

   // Response field positions inside rsp_tdata.
   localparam int ADDR_LSB  = dsa_pkg::IDX_W;
   localparam int COUNT_LSB = dsa_pkg::IDX_W + dsa_pkg::ADDR_W;

   // Report only this many mismatches in detail.
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [dsa_pkg::IDX_W-1:0]  slot_index;
      logic [dsa_pkg::ADDR_W-1:0] slot_address;
      dsa_pkg::status_type        status;
      logic [dsa_pkg::CNT_W-1:0]  active_count;
   } slot_result_type;

   class slot_scoreboard;
      logic [dsa_pkg::ADDR_W-1:0]   heap_base;
      logic [dsa_pkg::STRIDE_W-1:0] stride;
      logic [dsa_pkg::CNT_W-1:0]    capacity;
      logic [dsa_pkg::CNT_W-1:0]    fresh_next;
      logic [dsa_pkg::CNT_W-1:0]    stack_depth;
      logic [dsa_pkg::CNT_W-1:0]    handed_out;
      logic [dsa_pkg::IDX_W-1:0]    free_stack [SLOT_DEPTH];
      slot_result_type              expected_results [$];
      // Slots currently held by the requester, used to build sensible frees.
      logic [dsa_pkg::IDX_W-1:0]    held_slots [$];
      int unsigned                  failures;
      int unsigned                  checked;
      int unsigned                  grants;
      int unsigned                  reuses;
      int unsigned                  exhausted;
      int unsigned                  frees;
      int unsigned                  empty_frees;

      function new();
         heap_base   = dsa_pkg::HEAP_BASE_RST;
         stride      = dsa_pkg::STRIDE_RST;
         capacity    = dsa_pkg::CAPACITY_RST;
         fresh_next  = '0;
         stack_depth = '0;
         handed_out  = '0;
         failures    = 0;
         checked     = 0;
         grants      = 0;
         reuses      = 0;
         exhausted   = 0;
         frees       = 0;
         empty_frees = 0;
      endfunction

      function void write_register(logic [dsa_pkg::CSR_IDX_W-1:0] addr,
                                   logic [dsa_pkg::ADDR_W-1:0] data);
         case (addr)
            dsa_pkg::CSR_HEAP_BASE: heap_base = data;
            dsa_pkg::CSR_STRIDE:    stride = data[dsa_pkg::STRIDE_W-1:0];
            dsa_pkg::CSR_CAPACITY:  capacity = data[dsa_pkg::CNT_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned pending();
         return expected_results.size();
      endfunction

      // Apply one accepted request to the tracked state and queue its response.
      function void note_request(logic kind, logic [dsa_pkg::IDX_W-1:0] index);
         slot_result_type           want;
         logic [dsa_pkg::CNT_W-1:0] limit;
         bit                        granted;
         want    = '0;
         want.status = dsa_pkg::STATUS_OK;
         granted = 1'b0;
         // Capacity above the built depth saturates.
         limit = (capacity > SLOT_DEPTH) ? dsa_pkg::CNT_W'(SLOT_DEPTH) : capacity;
         if (kind == dsa_pkg::KIND_ALLOC) begin
            if (fresh_next < limit) begin
               want.slot_index = fresh_next[dsa_pkg::IDX_W-1:0];
               fresh_next++;
               granted = 1'b1;
            end else if (stack_depth != 0) begin
               stack_depth--;
               want.slot_index = free_stack[stack_depth];
               granted = 1'b1;
               reuses++;
            end
            if (granted) begin
               handed_out++;
               want.slot_address = heap_base + dsa_pkg::ADDR_W'(want.slot_index)
                                   * dsa_pkg::ADDR_W'(stride);
               held_slots.insert(held_slots.size(), want.slot_index);
               grants++;
            end else begin
               want.status = dsa_pkg::STATUS_OUT_OF_SLOTS;
               exhausted++;
            end
         end else if (handed_out == 0) begin
            // A free with nothing handed out changes nothing.
            want.status = dsa_pkg::STATUS_FREE_NONE_ACTIVE;
            empty_frees++;
         end else begin
            if (stack_depth < SLOT_DEPTH) begin
               free_stack[stack_depth] = index;
               stack_depth++;
            end
            handed_out--;
            frees++;
            for (int k = 0; k < held_slots.size(); k++) begin
               if (held_slots[k] == index) begin
                  held_slots.delete(k);
                  break;
               end
            end
         end
         want.active_count = handed_out;
         expected_results.insert(expected_results.size(), want);
      endfunction

      // Compare one accepted response with the oldest prediction.
      function void check_response(logic [87:0] data, logic [1:0] user);
         slot_result_type want;
         slot_result_type got;
         got.slot_index   = data[dsa_pkg::IDX_W-1:0];
         got.slot_address = data[ADDR_LSB +: dsa_pkg::ADDR_W];
         got.active_count = data[COUNT_LSB +: dsa_pkg::CNT_W];
         got.status       = dsa_pkg::status_type'(user);
         checked++;
         if (expected_results.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("ERROR: unexpected response: index %0d address %h status %0d active %0d",
                        got.slot_index, got.slot_address, got.status, got.active_count);
            return;
         end
         want = expected_results.pop_front();
         if (got.slot_index !== want.slot_index || got.slot_address !== want.slot_address ||
             got.status !== want.status || got.active_count !== want.active_count) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
               $display("ERROR: response %0d: expected index %0d address %h status %0d active %0d",
                        checked, want.slot_index, want.slot_address, want.status,
                        want.active_count);
               $display("       got      index %0d address %h status %0d active %0d",
                        got.slot_index, got.slot_address, got.status, got.active_count);
            end
         end
      endfunction

      // Any prediction still queued at the end is a missing response.
      function void close_out();
         if (expected_results.size() != 0) begin
            $display("ERROR: %0d responses never arrived", expected_results.size());
            failures += expected_results.size();
         end
      endfunction
   endclass

endpackage

>>> tb/descriptor_slot_allocator_tb.sv
// ----------------------------------------------------------------------------
// Descriptor slot allocator testbench
// Drives allocate and free requests through the stream ports with random
// gaps and response stalls, reprograms heap base, stride and capacity between
// phases, and checks every response against a scoreboard prediction.
// ----------------------------------------------------------------------------
module descriptor_slot_allocator_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES  = 11;
   localparam int SETTLE_CYCLES = 6;
   localparam int IDLE_LIMIT    = 1000;
   localparam int REQ_TDATA_W   = 16;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [REQ_TDATA_W-1:0]          req_tdata  = '0;  // [9:0] free_index
   logic [0:0]                      req_tuser  = '0;  // [0] kind
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   // [9:0] slot_index, [73:10] slot_address, [84:74] active_count
   logic [87:0]                     rsp_tdata;
   logic [1:0]                      rsp_tuser;  // [1:0] status
   logic                            csr_we     = 1'b0;
   logic [dsa_pkg::CSR_IDX_W-1:0]   csr_addr   = '0;
   logic [dsa_pkg::ADDR_W-1:0]      csr_wdata  = '0;

   int unsigned req_stall_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned settings      = 0;

   slot_scoreboard_pkg::slot_scoreboard sb = new();

   always #5 clock = ~clock;

   descriptor_slot_allocator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned pick_gap();
      if ($urandom_range(0, 99) < 85)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Send one request, optionally after an idle gap, and record it on acceptance.
   task automatic send_request(input logic kind, input logic [dsa_pkg::IDX_W-1:0] index);
      int unsigned gap;
      if ($urandom_range(0, 99) < req_stall_pct) begin
         gap = pick_gap();
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{(REQ_TDATA_W-dsa_pkg::IDX_W){1'b0}}, index};
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_request(kind, index);
   endtask

   // Hold off the sender until every response is in, then let the pipeline settle.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Program all three registers on consecutive cycles.
   task automatic write_config(input logic [dsa_pkg::ADDR_W-1:0] base,
                               input logic [dsa_pkg::STRIDE_W-1:0] stride,
                               input logic [dsa_pkg::CNT_W-1:0] cap);
      csr_we    <= 1'b1;
      csr_addr  <= dsa_pkg::CSR_HEAP_BASE;
      csr_wdata <= base;
      @(posedge clock);
      sb.write_register(dsa_pkg::CSR_HEAP_BASE, base);
      csr_addr  <= dsa_pkg::CSR_STRIDE;
      csr_wdata <= dsa_pkg::ADDR_W'(stride);
      @(posedge clock);
      sb.write_register(dsa_pkg::CSR_STRIDE, dsa_pkg::ADDR_W'(stride));
      csr_addr  <= dsa_pkg::CSR_CAPACITY;
      csr_wdata <= dsa_pkg::ADDR_W'(cap);
      @(posedge clock);
      sb.write_register(dsa_pkg::CSR_CAPACITY, dsa_pkg::ADDR_W'(cap));
      csr_we    <= 1'b0;
      settings++;
   endtask

   // One random phase of allocates and frees: frees mostly of slots actually held, some stray indexes.
   task automatic run_phase(input logic [dsa_pkg::ADDR_W-1:0] base,
                            input logic [dsa_pkg::STRIDE_W-1:0] stride,
                            input logic [dsa_pkg::CNT_W-1:0] cap, input int unsigned count,
                            input int unsigned alloc_pct, input int unsigned req_pct,
                            input int unsigned rsp_pct);
      logic                      kind;
      logic [dsa_pkg::IDX_W-1:0] index;
      drain_responses();
      write_config(base, stride, cap);
      req_stall_pct = req_pct;
      rsp_stall_pct = rsp_pct;
      for (int n = 0; n < count; n++) begin
         if (n == count / 2)
            drain_responses();
         index = dsa_pkg::IDX_W'($urandom_range(0, slot_scoreboard_pkg::SLOT_DEPTH - 1));
         if ($urandom_range(0, 99) < alloc_pct) begin
            kind = dsa_pkg::KIND_ALLOC;
         end else begin
            kind = dsa_pkg::KIND_FREE;
            if (sb.held_slots.size() != 0 && $urandom_range(0, 99) < 85)
               index = sb.held_slots[$urandom_range(0, sb.held_slots.size() - 1)];
         end
         send_request(kind, index);
      end
   endtask

   // Response side: check accepted responses and stall at random.
   initial begin
      int unsigned hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
            sb.check_response(rsp_tdata, rsp_tuser);
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 99) < rsp_stall_pct) begin
            hold = pick_gap() - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run if nothing moves on either channel for too long.
   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid === 1'b1 && req_tready === 1'b1) ||
             (rsp_tvalid === 1'b1 && rsp_tready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("ERROR: no request or response accepted for %0d cycles", IDLE_LIMIT);
      $display("descriptor_slot_allocator verification failed");
      $finish;
   end

   // Main sequence.
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset register values: frees with nothing handed out, then two fresh grants and a free.
      req_stall_pct = 30;
      rsp_stall_pct = 30;
      send_request(dsa_pkg::KIND_FREE, 10'd0);
      send_request(dsa_pkg::KIND_FREE, 10'd1023);
      send_request(dsa_pkg::KIND_ALLOC, 10'd1023);
      send_request(dsa_pkg::KIND_ALLOC, 10'd0);
      send_request(dsa_pkg::KIND_FREE, 10'd1);

      // Three slots, widest stride, base near the top so addresses wrap.
      drain_responses();
      write_config(64'hFFFF_FFFF_FFFF_FF00, 9'h1FF, 11'd3);
      send_request(dsa_pkg::KIND_ALLOC, 10'd0);
      send_request(dsa_pkg::KIND_ALLOC, 10'h155);
      send_request(dsa_pkg::KIND_ALLOC, 10'h2AA);
      // An index never handed out is still accepted and reused.
      send_request(dsa_pkg::KIND_FREE, 10'd1023);
      send_request(dsa_pkg::KIND_ALLOC, 10'd0);
      // The same index freed twice comes back twice.
      send_request(dsa_pkg::KIND_FREE, 10'd2);
      send_request(dsa_pkg::KIND_FREE, 10'd2);
      send_request(dsa_pkg::KIND_ALLOC, 10'd0);
      send_request(dsa_pkg::KIND_ALLOC, 10'd0);
      send_request(dsa_pkg::KIND_ALLOC, 10'd0);

      // Zero capacity and zero stride: only freed slots, all at the base.
      drain_responses();
      write_config(64'h0123_4567_89AB_CDEF, 9'd0, 11'd0);
      send_request(dsa_pkg::KIND_ALLOC, 10'd0);
      send_request(dsa_pkg::KIND_FREE, 10'd5);
      send_request(dsa_pkg::KIND_ALLOC, 10'd0);

      // Capacity beyond the built depth, then return everything and one more.
      drain_responses();
      write_config(64'd0, 9'd1, 11'h7FF);
      send_request(dsa_pkg::KIND_ALLOC, 10'd0);
      send_request(dsa_pkg::KIND_FREE, 10'd0);
      send_request(dsa_pkg::KIND_FREE, 10'd1);
      send_request(dsa_pkg::KIND_FREE, 10'd2);
      send_request(dsa_pkg::KIND_FREE, 10'd1023);
      send_request(dsa_pkg::KIND_FREE, 10'd511);

      // Random phases, small capacities first so the fresh pointer stays low.
      run_phase({$urandom, $urandom}, 9'd256, 11'd6, 150, 55, 20, 20);
      run_phase('1, 9'd1, 11'd0, 100, 50, 0, 0);
      run_phase({$urandom, $urandom}, 9'($urandom_range(1, 256)), 11'd40, 200, 60, 30, 10);
      run_phase({$urandom, $urandom}, 9'($urandom_range(1, 256)), 11'd40, 100, 25, 10, 30);
      run_phase(64'd0, 9'($urandom_range(1, 256)), 11'd1024, 250, 70, 15, 15);
      run_phase({$urandom, $urandom}, 9'h1FF, 11'h7FF, 300, 75, 25, 25);

      drain_responses();
      sb.close_out();

      $display("Checked %0d responses across %0d register settings: %0d grants, %0d reused,",
               sb.checked, settings, sb.grants, sb.reuses);
      $display("%0d out of slots, %0d frees, %0d frees with none active, %0d failures.",
               sb.exhausted, sb.frees, sb.empty_frees, sb.failures);
      if (sb.failures == 0)
         $display("descriptor_slot_allocator verification clean");
      else
         $display("descriptor_slot_allocator verification failed");
      $finish;
   end

endmodule
